FILE: rtl/core/mandel_pkg.sv
// ----------------------------------------------------------------------------
// mandel_pkg: shared types and constants for the escape-time pixel engine
// Fixed-point formats, configuration register indexes, controller states and
// the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mandel_pkg;

  // Coordinate format: signed, FRAC_BITS fraction bits in COORD_W bits
  localparam int COORD_W   = 32;
  localparam int FRAC_BITS = 28;
  localparam int ITER_W    = 16;
  localparam int PIX_W     = 12;
  localparam int DIM_W     = 13;
  localparam int CFG_W     = COORD_W;
  localparam int CFG_IDX_W = 3;
  localparam int COLOR_W   = 8;

  // Derived widths
  localparam int PROD_W     = 2 * COORD_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int MAP_DIFF_W = PIX_W + 2;
  localparam int MAP_PROD_W = MAP_DIFF_W + COORD_W;
  localparam int ROOT_N_W   = 2 * COLOR_W;
  localparam int ROOT_IDX_W = $clog2(COLOR_W);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [SUM_W-1:0]   wide_t;

  // Saturation bounds at the wide scale
  localparam wide_t COORD_HI = {{(SUM_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
  localparam wide_t COORD_LO = {{(SUM_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

  // Escape radius squared (4.0) at the product scale of 2*FRAC_BITS
  localparam logic [PROD_W:0] ESC_LIMIT =
    {{(PROD_W-2*FRAC_BITS-2){1'b0}}, 1'b1, {(2*FRAC_BITS+2){1'b0}}};

  // Register reset values
  localparam coord_t             SCALE_RST     = coord_t'(2097152);
  localparam coord_t             CENTER_RE_RST = coord_t'(-134217728);
  localparam coord_t             CENTER_IM_RST = coord_t'(0);
  localparam logic [ITER_W-1:0]  MAX_ITER_RST  = ITER_W'(256);
  localparam logic [DIM_W-1:0]   WIDTH_RST     = DIM_W'(640);
  localparam logic [DIM_W-1:0]   HEIGHT_RST    = DIM_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE_X      = 3'd0,
    CFG_SCALE_Y      = 3'd1,
    CFG_CENTER_RE    = 3'd2,
    CFG_CENTER_IM    = 3'd3,
    CFG_MAX_ITER     = 3'd4,
    CFG_IMAGE_WIDTH  = 3'd5,
    CFG_IMAGE_HEIGHT = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_ITER,
    ST_ROOT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic map;        // form the scaled pixel offsets
    logic seed;       // load c, clear z and the count
    logic iter;       // one z = z^2 + c step
    logic root_init;  // freeze the count, prepare the shade root
    logic root_step;  // one bit of the shade square root
  } dp_cmd_t;

  typedef struct packed {
    logic stop;       // escaped or limit reached
    logic root_last;  // last root bit in progress
  } dp_stat_t;

  // Clamp a wide signed value into the coordinate range
  function automatic coord_t sat_coord(input wide_t v);
    coord_t res;
    if (v > COORD_HI) begin
      res = COORD_HI[COORD_W-1:0];
    end else if (v < COORD_LO) begin
      res = COORD_LO[COORD_W-1:0];
    end else begin
      res = v[COORD_W-1:0];
    end
    return res;
  endfunction

endpackage

FILE: rtl/core/mandel_ctrl.sv
// ----------------------------------------------------------------------------
// mandel_ctrl: sequencer for the escape-time pixel engine
// Walks each pixel through mapping, iteration, shade root and result strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mandel_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  mandel_pkg::dp_stat_t stat,
  output mandel_pkg::dp_cmd_t  cmd,
  output logic                 busy,
  output logic                 done
);
  import mandel_pkg::*;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.map    = 1'b1;
          state_next = ST_SEED;
        end
      end
      ST_SEED: begin
        cmd.seed   = 1'b1;
        state_next = ST_ITER;
      end
      ST_ITER: begin
        if (stat.stop) begin
          cmd.root_init = 1'b1;
          state_next    = ST_ROOT;
        end else begin
          cmd.iter = 1'b1;
        end
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (stat.root_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        // result is shown this cycle; the next pixel may start alongside
        busy = 1'b0;
        done = 1'b1;
        if (start) begin
          cmd.map    = 1'b1;
          state_next = ST_SEED;
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Checks
  a_accept_seeds: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == ST_SEED))
    else $error("accepted pixel did not move to seeding");

  a_done_after_root: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == ST_ROOT))
    else $error("result strobe without finished shade root");

  a_one_command: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one datapath command at once");

endmodule

FILE: rtl/core/mandel_dp.sv
// ----------------------------------------------------------------------------
// mandel_dp: datapath of the escape-time pixel engine
// Maps the pixel to c, iterates z = z^2 + c one step per cycle with the
// escape test, and computes the green shade with a bit-serial square root.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mandel_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  mandel_pkg::dp_cmd_t                 cmd,
  output mandel_pkg::dp_stat_t                stat,
  input  logic [mandel_pkg::PIX_W-1:0]        pixel_col,
  input  logic [mandel_pkg::PIX_W-1:0]        pixel_row,
  input  mandel_pkg::coord_t                  scale_x,
  input  mandel_pkg::coord_t                  scale_y,
  input  mandel_pkg::coord_t                  center_re,
  input  mandel_pkg::coord_t                  center_im,
  input  logic [mandel_pkg::ITER_W-1:0]       max_iter,
  input  logic [mandel_pkg::DIM_W-1:0]        image_width,
  input  logic [mandel_pkg::DIM_W-1:0]        image_height,
  output logic [mandel_pkg::ITER_W-1:0]       iterations,
  output logic                                inside_res,
  output logic [mandel_pkg::COLOR_W-1:0]      red,
  output logic [mandel_pkg::COLOR_W-1:0]      green,
  output logic [mandel_pkg::COLOR_W-1:0]      blue
);
  import mandel_pkg::*;

  // Pixel offsets from the image center
  logic signed [MAP_DIFF_W-1:0] col_off, row_off;
  logic signed [MAP_PROD_W-1:0] map_re, map_im;

  // Iteration state
  coord_t            cr, ci, zr, zi;
  logic [ITER_W-1:0] count;
  logic              limit_hit;

  // Squares and cross product of z
  logic signed [PROD_W-1:0] rr, ii, ri;
  logic [PROD_W:0]          mag;
  wide_t                    re_diff, re_sum, im_sum;

  // Shade root
  logic [ROOT_N_W-1:0]   root_n;
  logic [COLOR_W-1:0]    root, trial;
  logic [ROOT_IDX_W-1:0] root_idx;
  logic [ROOT_N_W-1:0]   trial_sq, root_sq;
  logic [COLOR_W-1:0]    shade;

  assign col_off = signed'({{(MAP_DIFF_W-PIX_W){1'b0}}, pixel_col})
                 - signed'({{(MAP_DIFF_W-DIM_W+1){1'b0}}, image_width[DIM_W-1:1]});
  assign row_off = signed'({{(MAP_DIFF_W-PIX_W){1'b0}}, pixel_row})
                 - signed'({{(MAP_DIFF_W-DIM_W+1){1'b0}}, image_height[DIM_W-1:1]});

  // Register the scaled offsets
  always_ff @(posedge clk) begin
    if (cmd.map) begin
      map_re <= col_off * scale_x;
      map_im <= row_off * scale_y;
    end
  end

  // Escape test and update terms
  assign rr      = zr * zr;
  assign ii      = zi * zi;
  assign ri      = zr * zi;
  assign mag     = {1'b0, rr} + {1'b0, ii};
  assign re_diff = wide_t'(rr) - wide_t'(ii);
  assign re_sum  = (re_diff >>> FRAC_BITS) + wide_t'(cr);
  assign im_sum  = (wide_t'(ri) >>> (FRAC_BITS - 1)) + wide_t'(ci);

  assign stat.stop = (mag >= ESC_LIMIT) || (count >= max_iter);

  // Seed and iterate z
  always_ff @(posedge clk) begin
    if (cmd.seed) begin
      cr    <= sat_coord(wide_t'(map_re) + wide_t'(center_re));
      ci    <= sat_coord(wide_t'(map_im) + wide_t'(center_im));
      zr    <= '0;
      zi    <= '0;
      count <= '0;
    end else if (cmd.iter) begin
      zr    <= sat_coord(re_sum);
      zi    <= sat_coord(im_sum);
      count <= count + ITER_W'(1);
    end
  end

  // Shade root: one result bit per cycle, most significant first
  assign shade          = count[COLOR_W-1:0];
  assign trial          = root | (COLOR_W'(1) << root_idx);
  assign trial_sq       = trial * trial;
  assign root_sq        = root * root;
  assign stat.root_last = (root_idx == '0);

  always_ff @(posedge clk) begin
    if (cmd.root_init) begin
      limit_hit <= (count == max_iter);
      root_n    <= {shade, {COLOR_W{1'b0}}} - ROOT_N_W'(shade);
      root      <= '0;
      root_idx  <= ROOT_IDX_W'(COLOR_W - 1);
    end else if (cmd.root_step) begin
      if (trial_sq <= root_n) begin
        root <= trial;
      end
      root_idx <= root_idx - ROOT_IDX_W'(1);
    end
  end

  // Result fields, black when the limit was reached
  assign iterations = count;
  assign inside_res = limit_hit;
  assign red        = limit_hit ? '0 : shade;
  assign green      = limit_hit ? '0 : root;
  assign blue       = limit_hit ? '0 : '1;

  // Checks
  a_iter_below_limit: assert property (@(posedge clk) disable iff (rst)
    cmd.iter |-> (count < max_iter))
    else $error("iteration step at or past the limit");

  a_inside_flag: assert property (@(posedge clk) disable iff (rst)
    cmd.root_init |=> (limit_hit == (count == max_iter)))
    else $error("inside flag disagrees with final count");

  a_root_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.root_step |=> (root_sq <= root_n))
    else $error("shade root overshoots its operand");

endmodule

FILE: rtl/core/mandelbrot_escape_time_pixel_top.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_top: escape-time pixel engine
// After start is accepted the pixel is mapped, seeded, iterated N times
// (N = iterations), then the shade root runs and done rises; the result
// transfers at the edge that ends the done cycle. A new start is taken
// in the done cycle. The z = z^2 + c loop runs one complex step per cycle.
// Results are strobed for one cycle on done; the receiver cannot stall.
// Reset (rst, synchronous) idles the sequencer and loads register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mandelbrot_escape_time_pixel_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [mandel_pkg::PIX_W-1:0]       pixel_col,
  input  logic [mandel_pkg::PIX_W-1:0]       pixel_row,
  input  logic                               cfg_we,
  input  logic [mandel_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [mandel_pkg::CFG_W-1:0]       cfg_data,
  output logic                               done,
  output logic [mandel_pkg::ITER_W-1:0]      iterations,
  output logic                               inside_res,
  output logic [mandel_pkg::COLOR_W-1:0]     red,
  output logic [mandel_pkg::COLOR_W-1:0]     green,
  output logic [mandel_pkg::COLOR_W-1:0]     blue
);
  import mandel_pkg::*;

  coord_t            scale_x, scale_y, center_re, center_im;
  logic [ITER_W-1:0] max_iter;
  logic [DIM_W-1:0]  image_width, image_height;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_x      <= SCALE_RST;
      scale_y      <= SCALE_RST;
      center_re    <= CENTER_RE_RST;
      center_im    <= CENTER_IM_RST;
      max_iter     <= MAX_ITER_RST;
      image_width  <= WIDTH_RST;
      image_height <= HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_SCALE_X:      scale_x      <= cfg_data[COORD_W-1:0];
        CFG_SCALE_Y:      scale_y      <= cfg_data[COORD_W-1:0];
        CFG_CENTER_RE:    center_re    <= cfg_data[COORD_W-1:0];
        CFG_CENTER_IM:    center_im    <= cfg_data[COORD_W-1:0];
        CFG_MAX_ITER:     max_iter     <= cfg_data[ITER_W-1:0];
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data[DIM_W-1:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg_data[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mandel_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  mandel_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .pixel_col    (pixel_col),
    .pixel_row    (pixel_row),
    .scale_x      (scale_x),
    .scale_y      (scale_y),
    .center_re    (center_re),
    .center_im    (center_im),
    .max_iter     (max_iter),
    .image_width  (image_width),
    .image_height (image_height),
    .iterations   (iterations),
    .inside_res   (inside_res),
    .red          (red),
    .green        (green),
    .blue         (blue)
  );

endmodule

FILE: sim/mandelbrot_escape_time_pixel_top_test.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_top_test: escape-time pixel engine testbench
// Loads views through the register port, sends pixel commands with random
// pacing and checks every strobed result against an escape-time predictor
// kept here: mapping with saturation, fixed-point z = z^2 + c loop, shading.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mandelbrot_escape_time_pixel_top_test;
  import mandel_pkg::*;

  // Bound on the whole run before it counts as hung
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam longint unsigned ESCAPE_RADIUS_SQ = 64'd4 << (2 * FRAC_BITS);
  localparam longint COORD_MAX = (longint'(1) << (COORD_W - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;
  localparam int RANDOM_VIEWS = 10;
  localparam int PIXELS_PER_VIEW = 123;

  typedef struct packed {
    coord_t              scale_x;
    coord_t              scale_y;
    coord_t              center_re;
    coord_t              center_im;
    logic [ITER_W-1:0]   max_iter;
    logic [DIM_W-1:0]    image_width;
    logic [DIM_W-1:0]    image_height;
  } view_t;

  typedef struct packed {
    logic [ITER_W-1:0]   iterations;
    logic                in_set;
    logic [COLOR_W-1:0]  red;
    logic [COLOR_W-1:0]  green;
    logic [COLOR_W-1:0]  blue;
  } pixel_shade_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [PIX_W-1:0]      pixel_col;
  logic [PIX_W-1:0]      pixel_row;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_W-1:0]      cfg_data;
  logic                  done;
  logic [ITER_W-1:0]     iterations;
  logic                  inside_res;
  logic [COLOR_W-1:0]    red;
  logic [COLOR_W-1:0]    green;
  logic [COLOR_W-1:0]    blue;

  view_t                 view;
  pixel_shade_t          pending_shades[$];
  pixel_shade_t          shade_want;
  int                    mismatch_count = 0;
  int                    cycle_count = 0;
  bit                    pace_gaps = 1'b1;

  mandelbrot_escape_time_pixel_top dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .pixel_col  (pixel_col),
    .pixel_row  (pixel_row),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .done       (done),
    .iterations (iterations),
    .inside_res (inside_res),
    .red        (red),
    .green      (green),
    .blue       (blue)
  );

  always #10 clk = ~clk;

  // Clamp into the signed coordinate range
  function automatic longint clamp_coord(input longint v);
    if (v > COORD_MAX) begin
      return COORD_MAX;
    end
    if (v < COORD_MIN) begin
      return COORD_MIN;
    end
    return v;
  endfunction

  // Map the pixel to c, run the escape loop and shade the count
  function automatic pixel_shade_t predict_escape(input logic [PIX_W-1:0] col,
                                                  input logic [PIX_W-1:0] row);
    pixel_shade_t shade;
    longint cr, ci, zr, zi, rr, ii, ri;
    int unsigned cnt, band, root;
    cr = clamp_coord((longint'(col) - longint'(view.image_width >> 1))
                     * longint'(view.scale_x) + longint'(view.center_re));
    ci = clamp_coord((longint'(row) - longint'(view.image_height >> 1))
                     * longint'(view.scale_y) + longint'(view.center_im));
    zr = 0;
    zi = 0;
    rr = 0;
    ii = 0;
    cnt = 0;
    while (($unsigned(rr) + $unsigned(ii) < ESCAPE_RADIUS_SQ) && (cnt < view.max_iter)) begin
      ri = zr * zi;
      zr = clamp_coord(((rr - ii) >>> FRAC_BITS) + cr);
      zi = clamp_coord((ri >>> (FRAC_BITS - 1)) + ci);
      rr = zr * zr;
      ii = zi * zi;
      cnt++;
    end
    shade = '0;
    shade.iterations = cnt[ITER_W-1:0];
    shade.in_set = (cnt == view.max_iter);
    if (!shade.in_set) begin
      band = cnt & 255;
      root = 0;
      while ((root + 1) * (root + 1) <= band * 255) begin
        root++;
      end
      shade.red = band[COLOR_W-1:0];
      shade.green = root[COLOR_W-1:0];
      shade.blue = 8'd255;
    end
    return shade;
  endfunction

  // Draw a view: mostly framed on the set, sometimes raw noise
  function automatic view_t random_view();
    view_t v;
    longint span;
    v.max_iter = ITER_W'($urandom_range(1, 300));
    if ($urandom_range(0, 4) == 0) begin
      v.scale_x = coord_t'($urandom);
      v.scale_y = coord_t'($urandom);
      v.center_re = coord_t'($urandom);
      v.center_im = coord_t'($urandom);
      v.image_width = DIM_W'($urandom);
      v.image_height = DIM_W'($urandom);
    end else begin
      v.image_width = DIM_W'($urandom_range(1, 4096));
      v.image_height = DIM_W'($urandom_range(1, 4096));
      span = longint'($urandom_range(32'd1 << FRAC_BITS, 32'd4 << FRAC_BITS));
      v.scale_x = coord_t'(span / longint'(v.image_width));
      span = longint'($urandom_range(32'd1 << FRAC_BITS, 32'd4 << FRAC_BITS));
      v.scale_y = coord_t'(span / longint'(v.image_height));
      if ($urandom_range(0, 3) == 0) begin
        v.scale_x = -v.scale_x;
      end
      if ($urandom_range(0, 3) == 0) begin
        v.scale_y = -v.scale_y;
      end
      // Real part in [-1.5, 0.5], imaginary part in [-1, 1]
      v.center_re = coord_t'($urandom_range(0, 32'd2 << FRAC_BITS)) - coord_t'(32'd3 << 27);
      v.center_im = coord_t'($urandom_range(0, 32'd2 << FRAC_BITS)) - coord_t'(32'd1 << 28);
    end
    return v;
  endfunction

  // Send one pixel command and record its expected shade on transfer
  task automatic drive_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row);
    int gap;
    gap = pace_gaps ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    pixel_col <= col;
    pixel_row <= row;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_shades.push_back(predict_escape(col, row));
  endtask

  // Drop start, wait out every pending shade, then let the engine go quiet
  task automatic settle_engine();
    start <= 1'b0;
    @(posedge clk);
    while (pending_shades.size() != 0 || busy) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
    cfg_addr <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  // Write all seven registers back to back; narrow ones carry junk upper bits
  task automatic load_view(input view_t v);
    logic [CFG_W-1:0] junk;
    junk = $urandom;
    cfg_we <= 1'b1;
    put_reg(CFG_SCALE_X, v.scale_x);
    put_reg(CFG_SCALE_Y, v.scale_y);
    put_reg(CFG_CENTER_RE, v.center_re);
    put_reg(CFG_CENTER_IM, v.center_im);
    put_reg(CFG_MAX_ITER, {junk[CFG_W-1:ITER_W], v.max_iter});
    put_reg(CFG_IMAGE_WIDTH, {junk[CFG_W-1:DIM_W], v.image_width});
    put_reg(CFG_IMAGE_HEIGHT, {~junk[CFG_W-1:DIM_W], v.image_height});
    cfg_we <= 1'b0;
    view = v;
  endtask

  task automatic check_field(input string name, input logic [ITER_W-1:0] want,
                             input logic [ITER_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Default view straight out of reset, with saturation at the far corner
  task automatic test_reset_view();
    drive_pixel(12'd320, 12'd240);
    drive_pixel(12'd0, 12'd0);
    drive_pixel(12'd4095, 12'd4095);
    drive_pixel(12'd0, 12'd240);
    drive_pixel(12'd639, 12'd479);
    settle_engine();
  endtask

  // Zero iteration limit: count 0, always in the set
  task automatic test_zero_limit();
    view_t v;
    v = view;
    v.max_iter = '0;
    load_view(v);
    drive_pixel(12'd320, 12'd240);
    drive_pixel(12'd4095, 12'd0);
    settle_engine();
  endtask

  // Zero, one, full and oversize image dimensions
  task automatic test_size_extremes();
    view_t v;
    v.scale_x = coord_t'(2097152);
    v.scale_y = coord_t'(2097152);
    v.center_re = '0;
    v.center_im = '0;
    v.max_iter = ITER_W'(64);
    v.image_width = '0;
    v.image_height = DIM_W'(8191);
    load_view(v);
    drive_pixel(12'd0, 12'd0);
    drive_pixel(12'd2048, 12'd4095);
    settle_engine();
    v.image_width = DIM_W'(1);
    v.image_height = DIM_W'(1);
    load_view(v);
    drive_pixel(12'd0, 12'd0);
    settle_engine();
    v.image_width = DIM_W'(4096);
    v.image_height = DIM_W'(4096);
    load_view(v);
    drive_pixel(12'd4095, 12'd2048);
    settle_engine();
  endtask

  // Extreme steps and centers drive the mapping into both saturation rails
  task automatic test_coord_saturation();
    view_t v;
    v.scale_x = coord_t'(32'h8000_0000);
    v.scale_y = coord_t'(32'h7FFF_FFFF);
    v.center_re = coord_t'(32'h7FFF_FFFF);
    v.center_im = coord_t'(32'h8000_0000);
    v.max_iter = ITER_W'(32);
    v.image_width = DIM_W'(640);
    v.image_height = DIM_W'(480);
    load_view(v);
    drive_pixel(12'd0, 12'd0);
    drive_pixel(12'd4095, 12'd4095);
    drive_pixel(12'd320, 12'd240);
    drive_pixel(12'd321, 12'd239);
    settle_engine();
  endtask

  // Largest limit: c = 0 runs the full count, c just past the cusp escapes late
  task automatic test_deep_limit();
    view_t v;
    v.scale_x = coord_t'(2097152);
    v.scale_y = coord_t'(2097152);
    v.center_re = '0;
    v.center_im = '0;
    v.max_iter = '1;
    v.image_width = DIM_W'(640);
    v.image_height = DIM_W'(480);
    load_view(v);
    drive_pixel(12'd320, 12'd240);
    drive_pixel(12'd354, 12'd240);
    settle_engine();
  endtask

  // Random views, mostly pixels inside the image, some anywhere
  task automatic test_random_views();
    view_t v;
    logic [PIX_W-1:0] col, row;
    int col_top, row_top;
    for (int k = 0; k < RANDOM_VIEWS; k++) begin
      v = random_view();
      load_view(v);
      pace_gaps = ($urandom_range(0, 3) != 0);
      col_top = (v.image_width == 0) ? 0 : int'(v.image_width) - 1;
      row_top = (v.image_height == 0) ? 0 : int'(v.image_height) - 1;
      if (col_top > 4095) col_top = 4095;
      if (row_top > 4095) row_top = 4095;
      for (int n = 0; n < PIXELS_PER_VIEW; n++) begin
        if ($urandom_range(0, 3) == 0) begin
          col = PIX_W'($urandom);
          row = PIX_W'($urandom);
        end else begin
          col = PIX_W'($urandom_range(0, col_top));
          row = PIX_W'($urandom_range(0, row_top));
        end
        drive_pixel(col, row);
      end
      settle_engine();
    end
    pace_gaps = 1'b1;
  endtask

  // Compare each strobed result with the oldest pending shade
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_shades.size() == 0) begin
        $display("%0t: result with nothing pending, expected none, got iterations %0d",
                 $time, iterations);
        mismatch_count++;
      end else begin
        shade_want = pending_shades.pop_front();
        check_field("iterations", shade_want.iterations, iterations);
        check_field("inside_res", ITER_W'(shade_want.in_set), ITER_W'(inside_res));
        check_field("red", ITER_W'(shade_want.red), ITER_W'(red));
        check_field("green", ITER_W'(shade_want.green), ITER_W'(green));
        check_field("blue", ITER_W'(shade_want.blue), ITER_W'(blue));
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d shades still pending", $time, pending_shades.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    cfg_we <= 1'b0;
    cfg_addr <= CFG_SCALE_X;
    cfg_data <= '0;
    pixel_col <= '0;
    pixel_row <= '0;
    view = '{scale_x: SCALE_RST, scale_y: SCALE_RST, center_re: CENTER_RE_RST,
             center_im: CENTER_IM_RST, max_iter: MAX_ITER_RST,
             image_width: WIDTH_RST, image_height: HEIGHT_RST};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_reset_view();
    test_zero_limit();
    test_size_extremes();
    test_coord_saturation();
    test_deep_limit();
    test_random_views();
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: mandelbrot_escape_time_pixel_top.f
rtl/core/mandel_pkg.sv
rtl/core/mandel_ctrl.sv
rtl/core/mandel_dp.sv
rtl/core/mandelbrot_escape_time_pixel_top.sv
sim/mandelbrot_escape_time_pixel_top_test.sv
